[src/bfpc_pkg.sv]
// Package: shared constants, types and masks for the Boolean function Post classifier.
package bfpc_pkg;

    localparam int MAX_VARS    = 6;
    localparam int TT_W        = 1 << MAX_VARS;
    localparam int NV_W        = 3;
    localparam int CLS_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [TT_W-1:0] t_word;
    typedef logic [NV_W-1:0] t_nvars;

    // One bit per Post class, self-dual in bit 0.
    typedef struct packed {
        logic pres_zero;
        logic pres_one;
        logic monotone;
        logic linear;
        logic self_dual;
    } t_bfpc_flags;

    typedef struct packed {
        t_word       coeffs;
        t_bfpc_flags flags;
        logic        last;
    } t_bfpc_entry;

    localparam t_bfpc_flags CLS_ALL = '1;

    // Positions whose index has bit b set.
    localparam t_word BIT_SET_MASK [MAX_VARS] = '{
        64'hAAAA_AAAA_AAAA_AAAA,
        64'hCCCC_CCCC_CCCC_CCCC,
        64'hF0F0_F0F0_F0F0_F0F0,
        64'hFF00_FF00_FF00_FF00,
        64'hFFFF_0000_FFFF_0000,
        64'hFFFF_FFFF_0000_0000
    };

    // Constant term plus the single-variable monomials.
    localparam t_word LIN_ALLOWED = 64'h0000_0001_0001_0117;

endpackage

[src/bfpc_if.sv]
// Interfaces: input and result channels with valid/ready handshake.
interface bfpc_in_if import bfpc_pkg::*; ();
    logic   valid;
    logic   ready;
    t_word  truth_table;
    t_nvars num_vars;
    logic   last_of_system;

    modport source (output valid, output truth_table, output num_vars,
                    output last_of_system, input ready);
    modport sink   (input valid, input truth_table, input num_vars,
                    input last_of_system, output ready);
endinterface

interface bfpc_out_if import bfpc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word anf_coeffs;
    logic  self_dual;
    logic  linear;
    logic  monotone;
    logic  preserves_one;
    logic  preserves_zero;
    logic  system_complete;
    logic  end_of_system;

    modport source (output valid, output anf_coeffs, output self_dual, output linear,
                    output monotone, output preserves_one, output preserves_zero,
                    output system_complete, output end_of_system, input ready);
    modport sink   (input valid, input anf_coeffs, input self_dual, input linear,
                    input monotone, input preserves_one, input preserves_zero,
                    input system_complete, input end_of_system, output ready);
endinterface

[src/boolean_function_post_classifier.sv]
// Boolean function Post classifier with ANF transform, completeness accumulator.
// Takes one truth table of up to six variables per cycle and returns its ANF
// coefficients, the five Post class flags and the running completeness of the
// current system. Throughput is one item per clock while the output accepts
// results: the classify network in the front end handles a whole table in the
// accept cycle and writes it into a two-entry queue; the back end pops it from
// the queue into the result register, so a result passes through the queue and
// the result register before it is visible. The queue keeps input ready high
// while a result waits, until both entries are occupied.
module boolean_function_post_classifier import bfpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfpc_in_if.sink    i_in,
    bfpc_out_if.source o_out
);

    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    t_bfpc_entry front_entry;
    t_bfpc_entry q_entry;

    bfpc_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (front_entry)
    );

    bfpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_entry (q_entry)
    );

    bfpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_entry   (q_entry),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into full queue");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> o_out.valid)
        else $error("popped item not in result register");

    a_zero_coeff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.preserves_zero == !o_out.anf_coeffs[0]))
        else $error("preserves_zero disagrees with constant term");

    a_self_dual_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.self_dual) |-> (o_out.preserves_zero == o_out.preserves_one))
        else $error("self-dual function with unequal end entries");

endmodule

[src/bfpc_front.sv]
// Front end: accepts an item, computes ANF coefficients and Post class flags.
module bfpc_front import bfpc_pkg::*; (
    bfpc_in_if.sink     i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_bfpc_entry o_entry
);

    function automatic t_word f_mask(input t_nvars n);
        t_word m;
        for (int i = 0; i < TT_W; i++) begin
            m[i] = ((7'(i) >> n) == 7'd0);
        end
        return m;
    endfunction

    function automatic t_word f_mobius(input t_word t_in);
        t_word t;
        t = t_in;
        for (int b = 0; b < MAX_VARS; b++) begin
            t = t ^ ((t << (1 << b)) & BIT_SET_MASK[b]);
        end
        return t;
    endfunction

    function automatic logic f_self_dual(input t_word t, input t_nvars n);
        logic [MAX_VARS:0] res;
        logic              sel;
        sel = 1'b0;
        for (int k = 0; k <= MAX_VARS; k++) begin
            res[k] = 1'b1;
            for (int i = 0; i < TT_W; i++) begin
                if (i < (1 << k)) begin
                    res[k] = res[k] & (t[i] ^ t[i ^ ((1 << k) - 1)]);
                end
            end
            if (n == NV_W'(k)) begin
                sel = res[k];
            end
        end
        return sel;
    endfunction

    function automatic logic f_monotone(input t_word t, input t_word m, input t_nvars n);
        logic  ok;
        t_word clr;
        t_word lo;
        t_word hi;
        ok = 1'b1;
        for (int b = 0; b < MAX_VARS; b++) begin
            clr = ~BIT_SET_MASK[b] & m;
            lo  = t & clr;
            hi  = (t >> (1 << b)) & clr;
            if ((NV_W'(b) < n) && ((lo & ~hi) != '0)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic f_top_entry(input t_word t, input t_nvars n);
        logic v;
        v = 1'b0;
        for (int k = 0; k <= MAX_VARS; k++) begin
            if (n == NV_W'(k)) begin
                v = t[(1 << k) - 1];
            end
        end
        return v;
    endfunction

    t_nvars      n_sat;
    t_word       tbl_mask;
    t_word       tbl;
    t_word       coeffs;
    t_bfpc_flags flags;

    always_comb begin
        n_sat           = (i_in.num_vars > NV_W'(MAX_VARS)) ? NV_W'(MAX_VARS) : i_in.num_vars;
        tbl_mask        = f_mask(n_sat);
        tbl             = i_in.truth_table & tbl_mask;
        coeffs          = f_mobius(tbl) & tbl_mask;
        flags.self_dual = f_self_dual(tbl, n_sat);
        flags.linear    = ((coeffs & ~LIN_ALLOWED) == '0);
        flags.monotone  = f_monotone(tbl, tbl_mask, n_sat);
        flags.pres_one  = f_top_entry(tbl, n_sat);
        flags.pres_zero = ~tbl[0];
    end

    assign i_in.ready     = ~i_q_full;
    assign o_push         = i_in.valid & ~i_q_full;
    assign o_entry.coeffs = coeffs;
    assign o_entry.flags  = flags;
    assign o_entry.last   = i_in.last_of_system;

endmodule

[src/bfpc_queue.sv]
// Short FIFO between the classify front end and the result back end.
module bfpc_queue import bfpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_bfpc_entry i_entry,
    input  logic        i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_bfpc_entry o_entry
);

    t_bfpc_entry       r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

endmodule

[src/bfpc_back.sv]
// Back end: accumulates class escapes per system and holds the result register.
module bfpc_back import bfpc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_bfpc_entry i_entry,
    output logic        o_pop,
    bfpc_out_if.source  o_out
);

    t_bfpc_flags r_seen;
    t_bfpc_flags n_seen;
    t_bfpc_flags seen_upd;
    logic        r_valid;
    logic        n_valid;
    t_bfpc_entry r_res;
    logic        r_complete;

    always_comb begin
        o_pop    = ~i_q_empty & (~r_valid | o_out.ready);
        seen_upd = r_seen | ~i_entry.flags;
        n_seen   = r_seen;
        n_valid  = r_valid & ~o_out.ready;
        if (o_pop) begin
            n_seen  = i_entry.last ? '0 : seen_upd;
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_seen  <= n_seen;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res      <= i_entry;
            r_complete <= (seen_upd == CLS_ALL);
        end
    end

    assign o_out.valid           = r_valid;
    assign o_out.anf_coeffs      = r_res.coeffs;
    assign o_out.self_dual       = r_res.flags.self_dual;
    assign o_out.linear          = r_res.flags.linear;
    assign o_out.monotone        = r_res.flags.monotone;
    assign o_out.preserves_one   = r_res.flags.pres_one;
    assign o_out.preserves_zero  = r_res.flags.pres_zero;
    assign o_out.system_complete = r_complete;
    assign o_out.end_of_system   = r_res.last;

endmodule
